// ----- rtl/sfla_pkg.sv -----
// segregated free list allocator: shared constants, types and helper functions
// no dependencies; imported by sfla_ctrl, the top level and the testbench

package sfla_pkg;

    localparam int HEAP_BYTES    = 1048576;
    localparam int CHUNK_BYTES   = 4096;
    localparam int NUM_CLASSES   = 10;
    localparam int HEAP_WORDS    = HEAP_BYTES / 4;
    localparam int MEM_AW        = $clog2(HEAP_WORDS);
    localparam int BA_W          = $clog2(HEAP_BYTES) + 2;
    localparam int WORD_W        = 32;
    localparam int CLS_W         = $clog2(NUM_CLASSES);
    localparam int MIN_BLOCK     = 24;
    localparam int CLASS0_LIMIT  = 64;
    localparam int PRO_HDR       = (((4 * NUM_CLASSES) + 3) / 8) * 8 + 4;
    localparam int FIRST_BP      = PRO_HDR + 12;

    localparam int FUNC_W        = 2;
    localparam int REQ_W         = 21;
    localparam int ADDR_W        = 20;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC  = 2'd0,
        FN_FREE   = 2'd1,
        FN_RESIZE = 2'd2
    } func_t;

    typedef enum logic [5:0] {
        S_INIT_CLR, S_INIT_PH, S_INIT_PF, S_INIT_EPI,
        S_IDLE, S_DECODE,
        S_WALK, S_WALK_CHK,
        S_FREE0, S_FREE1,
        S_RZ0, S_RZ1, S_RZ2, S_RZ3,
        S_FIND_H, S_FIND_N, S_FIND_C,
        S_EXT0, S_EXT1, S_EXT2, S_EXT3,
        S_PL0, S_PL1, S_PL2, S_ALLOC_DONE,
        S_SP0, S_SP1, S_SP2, S_SP3,
        S_CO0, S_CO1, S_CO2, S_CO3, S_CO4, S_CO5,
        S_RM0, S_RM1, S_RM2, S_RM3, S_RM4,
        S_IN0, S_IN1, S_IN2, S_IN3, S_IN4,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [MEM_AW-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [REQ_W-1:0]  copy_bytes;
        logic [ADDR_W-1:0] copy_from;
        logic              copy_needed;
        logic              out_of_memory;
        logic [ADDR_W-1:0] result_addr;
    } result_t;

    function automatic logic [MEM_AW-1:0] word_addr(input logic [BA_W-1:0] ba);
        return ba[MEM_AW+1:2];
    endfunction

    function automatic logic [WORD_W-1:0] tag(input logic [BA_W-1:0] size, input logic alloc);
        return {{(WORD_W-BA_W){1'b0}}, size[BA_W-1:3], 2'b00, alloc};
    endfunction

    function automatic logic [BA_W-1:0] tag_size(input logic [WORD_W-1:0] w);
        return {w[BA_W-1:3], 3'b000};
    endfunction

    function automatic logic [BA_W-1:0] link_of(input logic [WORD_W-1:0] w);
        return w[BA_W-1:0];
    endfunction

    function automatic logic [CLS_W-1:0] class_of(input logic [BA_W-1:0] size);
        logic [CLS_W-1:0] c;
        c = '0;
        for (int i = 0; i < NUM_CLASSES - 1; i++)
        begin
            if (32'(size) > (32'(CLASS0_LIMIT) << i))
            begin
                c = c + CLS_W'(1);
            end
        end
        return c;
    endfunction

    function automatic logic [BA_W-1:0] adjust(input logic [REQ_W-1:0] s);
        logic [BA_W-1:0] t;
        t = BA_W'(s) + BA_W'(15);
        if (s <= REQ_W'(16))
        begin
            return BA_W'(MIN_BLOCK);
        end
        return {t[BA_W-1:3], 3'b000};
    endfunction

    function automatic logic [BA_W-1:0] grow(input logic [BA_W-1:0] want);
        logic [BA_W-1:0] w;
        w = want >> 2;
        if (w[0])
        begin
            w = w + BA_W'(1);
        end
        return w << 2;
    endfunction

endpackage

// ----- rtl/sfla_ram.sv -----
// generic single-clock ram: one write port, one registered read port
// no dependencies

module sfla_ram #(
    parameter int AW = 18,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/sfla_ctrl.sv -----
// allocator sequencer: tag walk, list search, split, coalesce and heap growth
// depends on sfla_pkg; drives the heap word memory

module sfla_ctrl
    import sfla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [FUNC_W-1:0] in_func,
    input  logic [REQ_W-1:0]  in_size,
    input  logic [ADDR_W-1:0] in_addr,
    output logic              in_ready,
    input  logic              out_free,
    output logic              out_load,
    output result_t           out_res,
    output mem_req_t          mem_req,
    input  logic [WORD_W-1:0] mem_rdata
);

    state_t state_reg, state_next;
    state_t lret_reg, lret_next;
    state_t cret_reg, cret_next;
    logic   init_reg, init_next;
    logic   [CLS_W-1:0] clr_reg, clr_next;

    logic [FUNC_W-1:0] func_reg, func_next;
    logic [REQ_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    result_t           res_reg, res_next;

    logic [BA_W-1:0]  a_reg, a_next;
    logic [CLS_W-1:0] c_reg, c_next;
    logic [BA_W-1:0]  b_reg, b_next;
    logic [BA_W-1:0]  old_reg, old_next;
    logic             wk_rz_reg, wk_rz_next;
    logic             rz_move_reg, rz_move_next;
    logic [BA_W-1:0]  it_reg, it_next;
    logic [BA_W-1:0]  pl_bp_reg, pl_bp_next;
    logic [BA_W-1:0]  cs_reg, cs_next;
    logic [BA_W-1:0]  brk_reg, brk_next;
    logic [BA_W-1:0]  ext_reg, ext_next;
    logic [BA_W-1:0]  sp_bp_reg, sp_bp_next;
    logic [BA_W-1:0]  sp_rest_reg, sp_rest_next;
    logic             sp_co_reg, sp_co_next;
    logic [BA_W-1:0]  co_bp_reg, co_bp_next;
    logic [BA_W-1:0]  co_size_reg, co_size_next;
    logic [WORD_W-1:0] pf_reg, pf_next;
    logic [BA_W-1:0]  rm_bp_reg, rm_bp_next;
    logic [BA_W-1:0]  prev_reg, prev_next;
    logic [BA_W-1:0]  nxt_reg, nxt_next;
    logic [BA_W-1:0]  ins_bp_reg, ins_bp_next;
    logic [BA_W-1:0]  ins_size_reg, ins_size_next;
    logic [CLS_W-1:0] ins_cls_reg, ins_cls_next;
    logic [BA_W-1:0]  hd_reg, hd_next;

    logic [BA_W-1:0] addr_ba;
    logic [BA_W-1:0] rd_size;
    logic [BA_W:0]   grow_sum;
    logic [BA_W:0]   ext_end;

    assign addr_ba  = BA_W'(addr_reg);
    assign rd_size  = tag_size(mem_rdata);
    assign grow_sum = {1'b0, rd_size} + {1'b0, old_reg};
    assign ext_end  = {1'b0, brk_reg} + {1'b0, ext_reg};

    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && out_free;
    assign out_res  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR;
            init_reg  <= 1'b1;
            clr_reg   <= '0;
            lret_reg  <= S_IDLE;
            cret_reg  <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            clr_reg   <= clr_next;
            lret_reg  <= lret_next;
            cret_reg  <= cret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        res_reg      <= res_next;
        a_reg        <= a_next;
        c_reg        <= c_next;
        b_reg        <= b_next;
        old_reg      <= old_next;
        wk_rz_reg    <= wk_rz_next;
        rz_move_reg  <= rz_move_next;
        it_reg       <= it_next;
        pl_bp_reg    <= pl_bp_next;
        cs_reg       <= cs_next;
        brk_reg      <= brk_next;
        ext_reg      <= ext_next;
        sp_bp_reg    <= sp_bp_next;
        sp_rest_reg  <= sp_rest_next;
        sp_co_reg    <= sp_co_next;
        co_bp_reg    <= co_bp_next;
        co_size_reg  <= co_size_next;
        pf_reg       <= pf_next;
        rm_bp_reg    <= rm_bp_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        ins_bp_reg   <= ins_bp_next;
        ins_size_reg <= ins_size_next;
        ins_cls_reg  <= ins_cls_next;
        hd_reg       <= hd_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        lret_next     = lret_reg;
        cret_next     = cret_reg;
        init_next     = init_reg;
        clr_next      = clr_reg;
        func_next     = func_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        res_next      = res_reg;
        a_next        = a_reg;
        c_next        = c_reg;
        b_next        = b_reg;
        old_next      = old_reg;
        wk_rz_next    = wk_rz_reg;
        rz_move_next  = rz_move_reg;
        it_next       = it_reg;
        pl_bp_next    = pl_bp_reg;
        cs_next       = cs_reg;
        brk_next      = brk_reg;
        ext_next      = ext_reg;
        sp_bp_next    = sp_bp_reg;
        sp_rest_next  = sp_rest_reg;
        sp_co_next    = sp_co_reg;
        co_bp_next    = co_bp_reg;
        co_size_next  = co_size_reg;
        pf_next       = pf_reg;
        rm_bp_next    = rm_bp_reg;
        prev_next     = prev_reg;
        nxt_next      = nxt_reg;
        ins_bp_next   = ins_bp_reg;
        ins_size_next = ins_size_reg;
        ins_cls_next  = ins_cls_reg;
        hd_next       = hd_reg;

        mem_req       = '0;

        unique case (state_reg)
            S_INIT_CLR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_AW'(clr_reg);
                mem_req.wdata = '0;
                clr_next      = clr_reg + CLS_W'(1);
                if (clr_reg == CLS_W'(NUM_CLASSES - 1))
                begin
                    state_next = S_INIT_PH;
                end
            end
            S_INIT_PH:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(BA_W'(PRO_HDR));
                mem_req.wdata = tag(BA_W'(8), 1'b1);
                state_next    = S_INIT_PF;
            end
            S_INIT_PF:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(BA_W'(PRO_HDR + 4));
                mem_req.wdata = tag(BA_W'(8), 1'b1);
                state_next    = S_INIT_EPI;
            end
            S_INIT_EPI:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(BA_W'(PRO_HDR + 8));
                mem_req.wdata = tag('0, 1'b1);
                brk_next      = BA_W'(FIRST_BP);
                ext_next      = grow(BA_W'(CHUNK_BYTES));
                state_next    = S_EXT0;
            end
            S_IDLE:
            begin
                init_next = 1'b0;
                if (in_valid)
                begin
                    func_next    = in_func;
                    size_next    = in_size;
                    addr_next    = in_addr;
                    res_next     = '0;
                    rz_move_next = 1'b0;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                a_next = adjust(size_reg);
                c_next = class_of(adjust(size_reg));
                b_next = BA_W'(FIRST_BP);
                unique case (func_t'(func_reg))
                    FN_ALLOC:
                    begin
                        state_next = (size_reg == '0) ? S_DONE : S_FIND_H;
                    end
                    FN_FREE:
                    begin
                        wk_rz_next = 1'b0;
                        state_next = (addr_reg == '0) ? S_DONE : S_WALK;
                    end
                    FN_RESIZE:
                    begin
                        if (size_reg == '0)
                        begin
                            wk_rz_next = 1'b0;
                            state_next = (addr_reg == '0) ? S_DONE : S_WALK;
                        end
                        else if (addr_reg == '0)
                        begin
                            state_next = S_FIND_H;
                        end
                        else
                        begin
                            wk_rz_next = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WALK:
            begin
                mem_req.raddr = word_addr(b_reg - BA_W'(4));
                state_next    = (b_reg < brk_reg) ? S_WALK_CHK : S_DONE;
            end
            S_WALK_CHK:
            begin
                if (rd_size == '0 || b_reg > addr_ba)
                begin
                    state_next = S_DONE;
                end
                else if (b_reg == addr_ba)
                begin
                    old_next = rd_size;
                    if (!mem_rdata[0])
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = wk_rz_reg ? S_RZ0 : S_FREE0;
                    end
                end
                else
                begin
                    b_next     = b_reg + rd_size;
                    state_next = S_WALK;
                end
            end
            S_FREE0:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(addr_ba - BA_W'(4));
                mem_req.wdata = tag(old_reg, 1'b0);
                state_next    = S_FREE1;
            end
            S_FREE1:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(addr_ba + old_reg - BA_W'(8));
                mem_req.wdata = tag(old_reg, 1'b0);
                co_bp_next    = addr_ba;
                co_size_next  = old_reg;
                cret_next     = S_DONE;
                state_next    = S_CO0;
            end
            S_RZ0:
            begin
                if (a_reg <= old_reg)
                begin
                    res_next.result_addr = addr_reg;
                    if (old_reg - a_reg >= BA_W'(MIN_BLOCK))
                    begin
                        sp_bp_next   = addr_ba;
                        sp_rest_next = old_reg - a_reg;
                        sp_co_next   = 1'b1;
                        cret_next    = S_DONE;
                        state_next   = S_SP0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    mem_req.raddr = word_addr(addr_ba + old_reg - BA_W'(4));
                    state_next    = S_RZ1;
                end
            end
            S_RZ1:
            begin
                if (!mem_rdata[0] && grow_sum >= {1'b0, a_reg})
                begin
                    cs_next              = grow_sum[BA_W-1:0];
                    rm_bp_next           = addr_ba + old_reg;
                    lret_next            = S_RZ2;
                    res_next.result_addr = addr_reg;
                    state_next           = S_RM0;
                end
                else
                begin
                    rz_move_next = 1'b1;
                    state_next   = S_FIND_H;
                end
            end
            S_RZ2:
            begin
                if (cs_reg - a_reg >= BA_W'(MIN_BLOCK))
                begin
                    sp_bp_next   = addr_ba;
                    sp_rest_next = cs_reg - a_reg;
                    sp_co_next   = 1'b1;
                    cret_next    = S_DONE;
                    state_next   = S_SP0;
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = word_addr(addr_ba - BA_W'(4));
                    mem_req.wdata = tag(cs_reg, 1'b1);
                    state_next    = S_RZ3;
                end
            end
            S_RZ3:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(addr_ba + cs_reg - BA_W'(8));
                mem_req.wdata = tag(cs_reg, 1'b1);
                state_next    = S_DONE;
            end
            S_FIND_H:
            begin
                mem_req.raddr = MEM_AW'(c_reg);
                state_next    = S_FIND_N;
            end
            S_FIND_N:
            begin
                it_next = link_of(mem_rdata);
                if (link_of(mem_rdata) == '0)
                begin
                    if (c_reg == CLS_W'(NUM_CLASSES - 1))
                    begin
                        ext_next   = grow((a_reg > BA_W'(CHUNK_BYTES)) ? a_reg
                                                                     : BA_W'(CHUNK_BYTES));
                        state_next = S_EXT0;
                    end
                    else
                    begin
                        c_next     = c_reg + CLS_W'(1);
                        state_next = S_FIND_H;
                    end
                end
                else
                begin
                    mem_req.raddr = word_addr(link_of(mem_rdata) - BA_W'(4));
                    state_next    = S_FIND_C;
                end
            end
            S_FIND_C:
            begin
                if (!mem_rdata[0] && rd_size >= a_reg)
                begin
                    pl_bp_next = it_reg;
                    cs_next    = rd_size;
                    state_next = S_PL0;
                end
                else
                begin
                    mem_req.raddr = word_addr(it_reg + BA_W'(4));
                    state_next    = S_FIND_N;
                end
            end
            S_EXT0:
            begin
                if (ext_end > (BA_W+1)'(HEAP_BYTES))
                begin
                    if (init_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_next.out_of_memory = 1'b1;
                        state_next             = S_DONE;
                    end
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = word_addr(brk_reg - BA_W'(4));
                    mem_req.wdata = tag(ext_reg, 1'b0);
                    state_next    = S_EXT1;
                end
            end
            S_EXT1:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(brk_reg + ext_reg - BA_W'(8));
                mem_req.wdata = tag(ext_reg, 1'b0);
                state_next    = S_EXT2;
            end
            S_EXT2:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(brk_reg + ext_reg - BA_W'(4));
                mem_req.wdata = tag('0, 1'b1);
                brk_next      = brk_reg + ext_reg;
                co_bp_next    = brk_reg;
                co_size_next  = ext_reg;
                cret_next     = init_reg ? S_IDLE : S_EXT3;
                state_next    = S_CO0;
            end
            S_EXT3:
            begin
                pl_bp_next = co_bp_reg;
                cs_next    = co_size_reg;
                state_next = S_PL0;
            end
            S_PL0:
            begin
                rm_bp_next = pl_bp_reg;
                lret_next  = S_PL1;
                state_next = S_RM0;
            end
            S_PL1:
            begin
                if (cs_reg - a_reg >= BA_W'(MIN_BLOCK))
                begin
                    sp_bp_next   = pl_bp_reg;
                    sp_rest_next = cs_reg - a_reg;
                    sp_co_next   = 1'b0;
                    lret_next    = S_ALLOC_DONE;
                    state_next   = S_SP0;
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = word_addr(pl_bp_reg - BA_W'(4));
                    mem_req.wdata = tag(cs_reg, 1'b1);
                    state_next    = S_PL2;
                end
            end
            S_PL2:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(pl_bp_reg + cs_reg - BA_W'(8));
                mem_req.wdata = tag(cs_reg, 1'b1);
                state_next    = S_ALLOC_DONE;
            end
            S_ALLOC_DONE:
            begin
                res_next.result_addr = pl_bp_reg[ADDR_W-1:0];
                if (rz_move_reg)
                begin
                    res_next.copy_needed = 1'b1;
                    res_next.copy_from   = addr_reg;
                    res_next.copy_bytes  = REQ_W'(old_reg - BA_W'(8));
                    state_next           = S_FREE0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SP0:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(sp_bp_reg - BA_W'(4));
                mem_req.wdata = tag(a_reg, 1'b1);
                state_next    = S_SP1;
            end
            S_SP1:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(sp_bp_reg + a_reg - BA_W'(8));
                mem_req.wdata = tag(a_reg, 1'b1);
                state_next    = S_SP2;
            end
            S_SP2:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(sp_bp_reg + a_reg - BA_W'(4));
                mem_req.wdata = tag(sp_rest_reg, 1'b0);
                state_next    = S_SP3;
            end
            S_SP3:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(sp_bp_reg + a_reg + sp_rest_reg - BA_W'(8));
                mem_req.wdata = tag(sp_rest_reg, 1'b0);
                if (sp_co_reg)
                begin
                    co_bp_next   = sp_bp_reg + a_reg;
                    co_size_next = sp_rest_reg;
                    state_next   = S_CO0;
                end
                else
                begin
                    ins_bp_next   = sp_bp_reg + a_reg;
                    ins_size_next = sp_rest_reg;
                    state_next    = S_IN0;
                end
            end
            S_CO0:
            begin
                mem_req.raddr = word_addr(co_bp_reg - BA_W'(8));
                state_next    = S_CO1;
            end
            S_CO1:
            begin
                pf_next       = mem_rdata;
                mem_req.raddr = word_addr(co_bp_reg + co_size_reg - BA_W'(4));
                state_next    = S_CO2;
            end
            S_CO2:
            begin
                if (!mem_rdata[0])
                begin
                    rm_bp_next   = co_bp_reg + co_size_reg;
                    co_size_next = co_size_reg + rd_size;
                    lret_next    = S_CO3;
                    state_next   = S_RM0;
                end
                else
                begin
                    state_next = S_CO3;
                end
            end
            S_CO3:
            begin
                if (!pf_reg[0])
                begin
                    rm_bp_next   = co_bp_reg - tag_size(pf_reg);
                    co_bp_next   = co_bp_reg - tag_size(pf_reg);
                    co_size_next = co_size_reg + tag_size(pf_reg);
                    lret_next    = S_CO4;
                    state_next   = S_RM0;
                end
                else
                begin
                    state_next = S_CO4;
                end
            end
            S_CO4:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(co_bp_reg - BA_W'(4));
                mem_req.wdata = tag(co_size_reg, 1'b0);
                state_next    = S_CO5;
            end
            S_CO5:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(co_bp_reg + co_size_reg - BA_W'(8));
                mem_req.wdata = tag(co_size_reg, 1'b0);
                ins_bp_next   = co_bp_reg;
                ins_size_next = co_size_reg;
                lret_next     = cret_reg;
                state_next    = S_IN0;
            end
            S_RM0:
            begin
                mem_req.raddr = word_addr(rm_bp_reg);
                state_next    = S_RM1;
            end
            S_RM1:
            begin
                prev_next     = link_of(mem_rdata);
                mem_req.raddr = word_addr(rm_bp_reg + BA_W'(4));
                state_next    = S_RM2;
            end
            S_RM2:
            begin
                nxt_next = link_of(mem_rdata);
                if (prev_reg != '0)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = word_addr(prev_reg + BA_W'(4));
                    mem_req.wdata = mem_rdata;
                    state_next    = S_RM4;
                end
                else
                begin
                    mem_req.raddr = word_addr(rm_bp_reg - BA_W'(4));
                    state_next    = S_RM3;
                end
            end
            S_RM3:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_AW'(class_of(rd_size));
                mem_req.wdata = WORD_W'(nxt_reg);
                state_next    = S_RM4;
            end
            S_RM4:
            begin
                if (nxt_reg != '0)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = word_addr(nxt_reg);
                    mem_req.wdata = WORD_W'(prev_reg);
                end
                state_next = lret_reg;
            end
            S_IN0:
            begin
                ins_cls_next  = class_of(ins_size_reg);
                mem_req.raddr = MEM_AW'(class_of(ins_size_reg));
                state_next    = S_IN1;
            end
            S_IN1:
            begin
                hd_next       = link_of(mem_rdata);
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(ins_bp_reg);
                mem_req.wdata = '0;
                state_next    = S_IN2;
            end
            S_IN2:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = word_addr(ins_bp_reg + BA_W'(4));
                mem_req.wdata = WORD_W'(hd_reg);
                state_next    = S_IN3;
            end
            S_IN3:
            begin
                if (hd_reg != '0)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = word_addr(hd_reg);
                    mem_req.wdata = WORD_W'(ins_bp_reg);
                end
                state_next = S_IN4;
            end
            S_IN4:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_AW'(ins_cls_reg);
                mem_req.wdata = WORD_W'(ins_bp_reg);
                state_next    = lret_reg;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/segregated_free_list_allocator_core.sv -----
// segregated free list allocator top level: stream ports, result register
// depends on sfla_pkg, sfla_ctrl and sfla_ram
//
//  port group   dir  word contents (lowest bit up)
//  s_*          in   tuser: func; tdata: req_size, block_addr
//  m_*          out  tdata: result_addr, out_of_memory, copy_needed, copy_from, copy_bytes
//
// one request at a time; the time taken depends on the heap contents: the blocks visited
// by the tag walk, the free list nodes searched, the list unlinks and inserts and the
// tag writes all go through the single heap memory
// after reset the list heads are cleared and the prologue, epilogue and first chunk are built
// a finished word waits in the output register while the next request is taken

module segregated_free_list_allocator_core
    import sfla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // req_size, block_addr
    input  logic [1:0]  s_tuser,  // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // result_addr, out_of_memory, copy_needed, copy_from, copy_bytes
);

    mem_req_t          mem_req;
    logic [WORD_W-1:0] mem_rdata;
    logic              ready;
    logic              out_load;
    result_t           out_res;

    logic              m_valid_reg, m_valid_next;
    result_t           m_res_reg, m_res_next;

    sfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_func   (s_tuser),
        .in_size   (s_tdata[REQ_W-1:0]),
        .in_addr   (s_tdata[REQ_W+ADDR_W-1:REQ_W]),
        .in_ready  (ready),
        .out_free  (!m_valid_reg || m_tready),
        .out_load  (out_load),
        .out_res   (out_res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    sfla_ram #(
        .AW (MEM_AW),
        .DW (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_res_next   = out_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign s_tready = ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg};

endmodule

// ----- verif/segregated_free_list_allocator_core_tb.sv -----
// testbench for segregated_free_list_allocator_core: directed and random alloc, free, resize
// requests checked word by word against a heap predictor kept in a scoreboard class
// depends on sfla_pkg and the rtl top level
`timescale 1ns / 1ps

module segregated_free_list_allocator_core_tb;
    import sfla_pkg::*;

    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 500000;
    localparam int SPLIT_MIN = 24;
    localparam int CLASS_BASE = 64;
    localparam int PRO_TAG = (((4 * NUM_CLASSES) + 3) / 8) * 8 + 4;
    localparam int BLOCK0 = PRO_TAG + 12;

    class heap_scoreboard;
        bit [31:0]   heap_mem [HEAP_WORDS];
        int unsigned brk;
        result_t     expected_q[$];
        int unsigned live_q[$];
        int          errors;
        int          n_checked;
        int          n_oom;
        int          n_copy;

        function int unsigned rd(int unsigned a);
            int unsigned i;
            i = a >> 2;
            return (i < HEAP_WORDS) ? heap_mem[i] : 0;
        endfunction

        function void wr(int unsigned a, int unsigned v);
            int unsigned i;
            i = a >> 2;
            if (i < HEAP_WORDS)
                heap_mem[i] = v;
        endfunction

        function int unsigned blk_size(int unsigned bp);
            return rd(bp - 4) & ~32'd7;
        endfunction

        function void put_tags(int unsigned bp, int unsigned sz, int unsigned al);
            wr(bp - 4, sz | al);
            wr(bp + sz - 8, sz | al);
        endfunction

        function int unsigned size_class(int unsigned sz);
            int unsigned c;
            c = 0;
            while (c + 1 < NUM_CLASSES && longint'(sz) > (longint'(CLASS_BASE) << c))
                c++;
            return c;
        endfunction

        function void link_in(int unsigned bp);
            int unsigned c;
            int unsigned head;
            c = size_class(blk_size(bp));
            head = heap_mem[c];
            wr(bp, 0);
            wr(bp + 4, head);
            if (head != 0)
                wr(head, bp);
            heap_mem[c] = bp;
        endfunction

        function void unlink(int unsigned bp);
            int unsigned prv;
            int unsigned nxt;
            prv = rd(bp);
            nxt = rd(bp + 4);
            if (prv != 0)
                wr(prv + 4, nxt);
            else
                heap_mem[size_class(blk_size(bp))] = nxt;
            if (nxt != 0)
                wr(nxt, prv);
        endfunction

        function int unsigned merge(int unsigned bp);
            int unsigned sz;
            int unsigned pfoot;
            int unsigned nb;
            int unsigned pb;
            sz = blk_size(bp);
            pfoot = rd(bp - 8);
            nb = bp + sz;
            if ((rd(nb - 4) & 1) == 0)
            begin
                unlink(nb);
                sz += blk_size(nb);
            end
            if ((pfoot & 1) == 0)
            begin
                pb = bp - (pfoot & ~32'd7);
                unlink(pb);
                sz += blk_size(pb);
                bp = pb;
            end
            put_tags(bp, sz, 0);
            link_in(bp);
            return bp;
        endfunction

        function int unsigned grow_heap(int unsigned bytes);
            int unsigned bp;
            if (longint'(brk) + bytes > longint'(HEAP_BYTES))
                return 0;
            bp = brk;
            put_tags(bp, bytes, 0);
            wr(bp + bytes - 4, 1);
            brk += bytes;
            return merge(bp);
        endfunction

        function int unsigned even_words(int unsigned want);
            int unsigned w;
            w = want / 4;
            if (w & 1)
                w++;
            return w * 4;
        endfunction

        function int unsigned first_fit(int unsigned asz);
            int unsigned it;
            int unsigned steps;
            for (int unsigned c = size_class(asz); c < NUM_CLASSES; c++)
            begin
                it = heap_mem[c];
                steps = 0;
                while (it != 0 && steps < HEAP_WORDS)
                begin
                    if ((rd(it - 4) & 1) == 0 && blk_size(it) >= asz)
                        return it;
                    it = rd(it + 4);
                    steps++;
                end
            end
            return 0;
        endfunction

        function void carve(int unsigned bp, int unsigned asz);
            int unsigned csz;
            csz = blk_size(bp);
            unlink(bp);
            if (csz - asz >= SPLIT_MIN)
            begin
                put_tags(bp, asz, 1);
                put_tags(bp + asz, csz - asz, 0);
                link_in(bp + asz);
            end
            else
            begin
                put_tags(bp, csz, 1);
            end
        endfunction

        function int unsigned round_req(int unsigned sz);
            return (sz <= 16) ? SPLIT_MIN : ((sz + 15) / 8) * 8;
        endfunction

        function int unsigned allocate(int unsigned sz, output bit oom);
            int unsigned a;
            int unsigned bp;
            oom = 0;
            if (sz == 0)
                return 0;
            a = round_req(sz);
            bp = first_fit(a);
            if (bp == 0)
            begin
                bp = grow_heap(even_words(a > CHUNK_BYTES ? a : CHUNK_BYTES));
                if (bp == 0)
                begin
                    oom = 1;
                    return 0;
                end
            end
            carve(bp, a);
            return bp;
        endfunction

        function bit owned(int unsigned addr);
            int unsigned b;
            int unsigned h;
            int unsigned s;
            b = BLOCK0;
            if (addr == 0)
                return 0;
            while (b < brk)
            begin
                h = rd(b - 4);
                s = h & ~32'd7;
                if (s == 0 || b > addr)
                    return 0;
                if (b == addr)
                    return (h & 1) != 0;
                b += s;
            end
            return 0;
        endfunction

        function void release_blk(int unsigned bp);
            if (!owned(bp))
                return;
            put_tags(bp, blk_size(bp), 0);
            void'(merge(bp));
        endfunction

        function void reset_heap();
            foreach (heap_mem[i])
                heap_mem[i] = 0;
            wr(PRO_TAG, 9);
            wr(PRO_TAG + 4, 9);
            wr(PRO_TAG + 8, 1);
            brk = BLOCK0;
            void'(grow_heap(even_words(CHUNK_BYTES)));
            expected_q.delete();
            live_q.delete();
        endfunction

        function void drop_live(int unsigned addr);
            foreach (live_q[i])
            begin
                if (live_q[i] == addr)
                begin
                    live_q.delete(i);
                    return;
                end
            end
        endfunction

        function int unsigned resize_blk(int unsigned sz, int unsigned addr, ref result_t r);
            int unsigned a;
            int unsigned old;
            int unsigned nb;
            int unsigned nh;
            int unsigned ns;
            int unsigned left;
            int unsigned res;
            bit oom;
            a = round_req(sz);
            old = blk_size(addr);
            if (a <= old)
            begin
                if (old - a >= SPLIT_MIN)
                begin
                    put_tags(addr, a, 1);
                    put_tags(addr + a, old - a, 0);
                    void'(merge(addr + a));
                end
                return addr;
            end
            nb = addr + old;
            nh = rd(nb - 4);
            ns = nh & ~32'd7;
            if ((nh & 1) == 0 && longint'(ns) + old >= a)
            begin
                left = ns + old - a;
                unlink(nb);
                if (left >= SPLIT_MIN)
                begin
                    put_tags(addr, a, 1);
                    put_tags(addr + a, left, 0);
                    void'(merge(addr + a));
                end
                else
                begin
                    put_tags(addr, ns + old, 1);
                end
                return addr;
            end
            res = allocate(sz, oom);
            r.out_of_memory = oom;
            if (res != 0)
            begin
                r.copy_needed = 1;
                r.copy_from = addr[ADDR_W-1:0];
                r.copy_bytes = REQ_W'(old - 8);
                release_blk(addr);
            end
            return res;
        endfunction

        function void note(logic [1:0] fn, int unsigned sz, int unsigned addr);
            result_t     r;
            int unsigned res;
            bit          oom;
            bit          was_owned;
            r = '0;
            res = 0;
            was_owned = owned(addr);
            case (fn)
                FN_ALLOC:
                begin
                    res = allocate(sz, oom);
                    r.out_of_memory = oom;
                end
                FN_FREE:
                begin
                    release_blk(addr);
                    if (was_owned)
                        drop_live(addr);
                end
                FN_RESIZE:
                begin
                    if (sz == 0)
                    begin
                        release_blk(addr);
                        if (was_owned)
                            drop_live(addr);
                    end
                    else if (addr == 0)
                    begin
                        res = allocate(sz, oom);
                        r.out_of_memory = oom;
                    end
                    else if (was_owned)
                    begin
                        res = resize_blk(sz, addr, r);
                        if (r.copy_needed)
                            drop_live(addr);
                    end
                end
                default: ;
            endcase
            if (res != 0 && !(fn == FN_RESIZE && res == addr))
                live_q.push_back(res);
            if (r.out_of_memory)
                n_oom++;
            if (r.copy_needed)
                n_copy++;
            r.result_addr = res[ADDR_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void check(result_t got);
            result_t e;
            n_checked++;
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing expected: %h", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.result_addr !== e.result_addr)
            begin
                $error("result_addr expected %h got %h", e.result_addr, got.result_addr);
                errors++;
            end
            if (got.out_of_memory !== e.out_of_memory)
            begin
                $error("out_of_memory expected %b got %b", e.out_of_memory, got.out_of_memory);
                errors++;
            end
            if (got.copy_needed !== e.copy_needed)
            begin
                $error("copy_needed expected %b got %b", e.copy_needed, got.copy_needed);
                errors++;
            end
            if (got.copy_from !== e.copy_from)
            begin
                $error("copy_from expected %h got %h", e.copy_from, got.copy_from);
                errors++;
            end
            if (got.copy_bytes !== e.copy_bytes)
            begin
                $error("copy_bytes expected %h got %h", e.copy_bytes, got.copy_bytes);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    heap_scoreboard sb;
    int burst_left;
    int idle_cycles;
    int n_sent;
    bit ready_always;

    segregated_free_list_allocator_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic push_req(logic [1:0] fn, int unsigned sz, int unsigned addr);
        s_tuser  <= fn;
        s_tdata  <= {7'b0, addr[19:0], sz[20:0]};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note(fn, sz, addr);
        n_sent++;
        @(negedge clk);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
        end
        else
        begin
            burst_left--;
        end
    endtask

    function automatic int unsigned pick_live();
        if (sb.live_q.size() == 0)
            return 0;
        return sb.live_q[$urandom_range(0, sb.live_q.size() - 1)];
    endfunction

    function automatic int unsigned rand_size();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return $urandom_range(1, 64);
        if (k < 90)
            return $urandom_range(65, 600);
        if (k < 98)
            return $urandom_range(601, 6000);
        return $urandom_range(6001, 1048576);
    endfunction

    task automatic directed_part();
        int unsigned a;
        int unsigned b;
        int unsigned big[$];
        push_req(FN_ALLOC, 0, 0);
        push_req(FN_ALLOC, 1, 0);
        push_req(FN_ALLOC, 16, 0);
        push_req(FN_ALLOC, 17, 0);
        push_req(FN_ALLOC, 4096, 0);
        push_req(FN_FREE, 0, 0);
        push_req(FN_FREE, 0, 20'hFFFFF);
        push_req(FN_UNUSED, 21'h1FFFFF, 20'hFFFFF);
        push_req(FN_FREE, 0, sb.live_q[0]);
        push_req(FN_RESIZE, 40, 0);
        a = sb.live_q[$];
        push_req(FN_RESIZE, 40, 0);
        b = sb.live_q[$];
        push_req(FN_FREE, 0, b);
        push_req(FN_RESIZE, 80, a);
        push_req(FN_RESIZE, 8, a);
        push_req(FN_ALLOC, 40, 0);
        push_req(FN_RESIZE, 2000, a);
        push_req(FN_RESIZE, 100, a);
        push_req(FN_RESIZE, 0, sb.live_q[$]);
        push_req(FN_ALLOC, 1048576, 0);
        repeat (4)
        begin
            push_req(FN_ALLOC, 300000, 0);
            if (sb.live_q.size() != 0)
                big.push_back(sb.live_q[$]);
        end
        push_req(FN_RESIZE, 900000, sb.live_q[0]);
        foreach (big[i])
            push_req(FN_FREE, 0, big[i]);
    endtask

    task automatic random_part(int count);
        int unsigned k;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, 99);
            if (sb.live_q.size() > 80 && k < 50)
                k = 50;
            if (k < 45)
                push_req(FN_ALLOC, rand_size(), $urandom_range(0, 1048575));
            else if (k < 75)
                push_req(FN_FREE, $urandom_range(0, 2097151),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1048575) : pick_live());
            else if (k < 97)
                push_req(FN_RESIZE, ($urandom_range(0, 15) == 0) ? 0 : rand_size(),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1048575) : pick_live());
            else
                push_req(FN_UNUSED, $urandom_range(0, 2097151), $urandom_range(0, 1048575));
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        ready_always = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 299) == 0)
                ready_always = ~ready_always;
            m_tready <= ready_always || ($urandom_range(0, 9) < 6);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check(result_t'(m_tdata[62:0]));
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        sb.reset_heap();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        burst_left = 0;
        idle_cycles = 0;
        n_sent = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        directed_part();
        random_part(1550);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("requests sent %0d, words checked %0d", n_sent, sb.n_checked);
        $display("out of memory seen %0d, moves with copy %0d", sb.n_oom, sb.n_copy);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
